// ===== rtl/core/pbrc_pkg.sv =====
package pbrc_pkg;

  // Default datapath geometry: level is Q(SAMPLE_BITS).(FRAC_BITS)
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int TIME_W    = 32;
  localparam int BPM_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int WEIGHT_W = 9;
  localparam int DECAY_W  = 16;
  localparam int GAP_W    = 16;
  localparam int WIN_W    = 16;
  localparam int SCALE_W  = 8;
  localparam int THRESH_W = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BEAT_GAP_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_SCALE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_THRESHOLD = 3'd5;

  // Reset values
  localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RST   = 9'd192;
  localparam logic [DECAY_W-1:0]  DECAY_FACTOR_RST    = 16'd63570;
  localparam logic [GAP_W-1:0]    MIN_BEAT_GAP_MS_RST = 16'd300;
  localparam logic [WIN_W-1:0]    WINDOW_MS_RST       = 16'd15000;
  localparam logic [SCALE_W-1:0]  BPM_SCALE_RST       = 8'd4;
  localparam logic [THRESH_W-1:0] TOUCH_THRESHOLD_RST = 12'd1900;

  // Q8 unity weight; larger weights clamp here
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  typedef struct packed {
    logic [WEIGHT_W-1:0] filter_weight;
    logic [DECAY_W-1:0]  decay_factor;
    logic [GAP_W-1:0]    min_beat_gap_ms;
    logic [WIN_W-1:0]    window_ms;
    logic [SCALE_W-1:0]  bpm_scale;
    logic [THRESH_W-1:0] touch_threshold;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [BPM_W-1:0] bpm;
  } res_t;

endpackage

// ===== rtl/core/pbrc_cfg_regs.sv =====
module pbrc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pbrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbrc_pkg::CFG_W-1:0]     cfg_wdata,
  output pbrc_pkg::cfg_t                 cfg
);
  import pbrc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_weight   <= FILTER_WEIGHT_RST;
      cfg.decay_factor    <= DECAY_FACTOR_RST;
      cfg.min_beat_gap_ms <= MIN_BEAT_GAP_MS_RST;
      cfg.window_ms       <= WINDOW_MS_RST;
      cfg.bpm_scale       <= BPM_SCALE_RST;
      cfg.touch_threshold <= TOUCH_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_WEIGHT:   cfg.filter_weight   <= cfg_wdata[WEIGHT_W-1:0];
        REG_DECAY_FACTOR:    cfg.decay_factor    <= cfg_wdata[DECAY_W-1:0];
        REG_MIN_BEAT_GAP_MS: cfg.min_beat_gap_ms <= cfg_wdata[GAP_W-1:0];
        REG_WINDOW_MS:       cfg.window_ms       <= cfg_wdata[WIN_W-1:0];
        REG_BPM_SCALE:       cfg.bpm_scale       <= cfg_wdata[SCALE_W-1:0];
        REG_TOUCH_THRESHOLD: cfg.touch_threshold <= cfg_wdata[THRESH_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// ===== rtl/core/pbrc_beat_core.sv =====
module pbrc_beat_core #(
  parameter int SAMPLE_BITS = pbrc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = pbrc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pbrc_pkg::cfg_t              cfg,
  input  logic                        step,
  input  logic [SAMPLE_BITS-1:0]      sample,
  input  logic [pbrc_pkg::TIME_W-1:0] time_ms,
  output pbrc_pkg::res_t              res
);
  import pbrc_pkg::*;

  localparam int LEVEL_W = SAMPLE_BITS + FRAC_BITS;
  localparam int SLOPE_W = LEVEL_W + 1;
  localparam int PROD_W  = SLOPE_W + WEIGHT_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DPROD_W = SLOPE_W + DECAY_W + 1;
  localparam int BSUM_W  = BPM_W + SCALE_W + 1;
  localparam int CMP_W   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  localparam logic [SUM_W-1:0]   RND_Q8  = SUM_W'(128);
  localparam logic [DPROD_W-1:0] RND_Q16 = DPROD_W'(32768);
  localparam logic [BSUM_W-1:0]  BPM_MAX = BSUM_W'({BPM_W{1'b1}});

  // State. The peak is kept before its per-sample decay; the decay factor
  // in force at that step is kept with it and applied on the next step.
  logic [LEVEL_W-1:0]        level;
  logic signed [SLOPE_W-1:0] peak_raw;
  logic [DECAY_W-1:0]        decay_used;
  logic [TIME_W-1:0]         last_beat;
  logic [TIME_W-1:0]         win_start;
  logic [BPM_W-1:0]          beat_count;

  logic [LEVEL_W-1:0]        s_lvl;
  logic [WEIGHT_W-1:0]       w_eff;
  logic signed [SLOPE_W-1:0] diff;
  logic signed [PROD_W-1:0]  wprod;
  logic [SUM_W-1:0]          sum;
  logic [LEVEL_W-1:0]        level_next;
  logic signed [SLOPE_W-1:0] slope;
  logic                      peak_neg;
  logic [SLOPE_W-1:0]        peak_mag;
  logic [DPROD_W-1:0]        dprod;
  logic [SLOPE_W-1:0]        mag_dec;
  logic signed [SLOPE_W-1:0] peak_cur;
  logic                      gap_ok;
  logic                      beat;
  logic                      count_inc;
  logic                      win_close;
  logic                      touch;
  logic [BSUM_W-1:0]         bprod;
  logic [BSUM_W-1:0]         bsum;

  // Low-pass: new = (256*S + w*(L - S) + 128) >> 8, same as w*L + (256-w)*S
  assign s_lvl = LEVEL_W'(sample) << FRAC_BITS;
  assign w_eff = (cfg.filter_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.filter_weight;
  assign diff  = $signed({1'b0, level}) - $signed({1'b0, s_lvl});
  assign wprod = PROD_W'(diff) * PROD_W'($signed({1'b0, w_eff}));
  assign sum   = (SUM_W'(s_lvl) << 8) + SUM_W'(wprod) + RND_Q8;
  assign level_next = sum[LEVEL_W+7:8];
  assign slope = $signed({1'b0, level_next}) - $signed({1'b0, level});

  // Decay of the stored peak, sign and magnitude, rounded
  assign peak_neg = peak_raw[SLOPE_W-1];
  assign peak_mag = peak_neg ? SLOPE_W'(-peak_raw) : SLOPE_W'(peak_raw);
  assign dprod    = DPROD_W'(peak_mag) * DPROD_W'(decay_used) + RND_Q16;
  assign mag_dec  = dprod[SLOPE_W+DECAY_W-1:DECAY_W];
  assign peak_cur = peak_neg ? -$signed(mag_dec) : $signed(mag_dec);

  // Wrap-safe time compares
  assign gap_ok    = (time_ms - last_beat) > TIME_W'(cfg.min_beat_gap_ms);
  assign win_close = (time_ms - win_start) >= TIME_W'(cfg.window_ms);
  assign beat      = (slope >= peak_cur) && gap_ok;
  assign count_inc = beat && (beat_count != {BPM_W{1'b1}});
  assign touch     = CMP_W'(sample) > CMP_W'(cfg.touch_threshold);

  // bpm from the updated count without chaining behind the increment
  assign bprod = BSUM_W'(beat_count) * BSUM_W'(cfg.bpm_scale);
  assign bsum  = bprod + (count_inc ? BSUM_W'(cfg.bpm_scale) : '0);

  assign res.valid = win_close && touch;
  assign res.bpm   = (bsum > BPM_MAX) ? {BPM_W{1'b1}} : bsum[BPM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= '0;
      peak_raw   <= '0;
      decay_used <= DECAY_FACTOR_RST;
      last_beat  <= '0;
      win_start  <= '0;
      beat_count <= '0;
    end else if (step) begin
      level      <= level_next;
      peak_raw   <= beat ? slope : peak_cur;
      decay_used <= cfg.decay_factor;
      if (beat) begin
        last_beat <= time_ms;
      end
      if (win_close) begin
        win_start  <= time_ms;
        beat_count <= '0;
      end else if (count_inc) begin
        beat_count <= beat_count + 1'b1;
      end
    end
  end

  a_win_restart: assert property (@(posedge clk) disable iff (rst)
    (step && win_close) |=> (beat_count == '0))
    else $error("count not cleared at window close");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (step && !win_close && count_inc) |=> (beat_count == $past(beat_count) + 1'b1))
    else $error("beat count did not advance on a beat");

  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(level) && $stable(peak_raw)))
    else $error("filter state moved without a word");

endmodule

// ===== rtl/core/pulse_beat_rate_counter_unit.sv =====
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata: sample, time_ms
// m_*      | out | m_tvalid/m_tready  | m_tdata: bpm
// cfg_*    | in  | cfg_we (no stall)  | cfg_index, cfg_wdata
//
// One word per cycle sustained while m_tready stays high; a word is registered in
// the input register, and its result (if any) shows on m_* in the cycle after it leaves it.
// The rate is set by the per-sample state loop (filter level, peak, count),
// which closes through the update logic back into the state registers.
// Reset (rst, synchronous) zeroes the state and loads register defaults.
// With a result on m_* and m_tready low, the result holds and one more word is held at the input.
module pulse_beat_rate_counter_unit #(
  parameter int SAMPLE_BITS = pbrc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = pbrc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [SAMPLE_BITS-1:0] sample, then time_ms (32), zero pad to bytes
  input  logic [((SAMPLE_BITS+pbrc_pkg::TIME_W+7)/8)*8-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] bpm
  output logic [pbrc_pkg::BPM_W-1:0]     m_tdata,
  input  logic                           cfg_we,
  input  logic [pbrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbrc_pkg::CFG_W-1:0]     cfg_wdata
);
  import pbrc_pkg::*;

  cfg_t cfg;
  res_t res;

  // Input register
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [TIME_W-1:0]      in_time;
  logic                   advance;

  // Word leaves the input register when the output slot is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
      in_time   <= s_tdata[SAMPLE_BITS+TIME_W-1:SAMPLE_BITS];
    end
  end

  pbrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pbrc_beat_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .sample  (in_sample),
    .time_ms (in_time),
    .res     (res)
  );

  // Output register: valid loads on every advance (data only with a result), drops when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= res.bpm;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled with empty register");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("accepted a word with both stages blocked");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(advance && res.valid))
    else $error("result appeared without a processed word");

endmodule

// ===== tb/tb_pulse_beat_rate_counter_unit.sv =====
`timescale 1ns / 100ps

module tb_pulse_beat_rate_counter_unit;
  import pbrc_pkg::*;

  localparam int SMP_W   = SAMPLE_BITS_DEF;
  localparam int S_W     = ((SMP_W + TIME_W + 7) / 8) * 8;
  localparam int SETTLE  = 6;     // input reg + output reg, plus margin
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_LEN    = 300;

  // Idle mix: who drops its side of the handshake, and how often.
  typedef enum {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;
  // How a directed row gets its expectation.
  typedef enum {EXP_MODEL, EXP_NONE, EXP_BPM} exp_t;
  typedef enum {ROW_WORD, ROW_REG} row_t;

  typedef struct {
    row_t                 kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [SMP_W-1:0]     smp;
    logic [TIME_W-1:0]    now;
    exp_t                 how;
    logic [BPM_W-1:0]     pinned;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // [11:0] sample, [43:12] time_ms, [47:44] zero pad
  logic [S_W-1:0]       s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  // [15:0] bpm
  logic [BPM_W-1:0]     m_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  pulse_beat_rate_counter_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block: registers and per-sample state
  cfg_t                pred_cfg;
  logic [19:0]         pred_level;      // Q12.8 filtered level
  logic signed [20:0]  pred_peak;       // decaying peak slope
  logic [TIME_W-1:0]   pred_last_beat;
  logic [TIME_W-1:0]   pred_win_start;
  logic [15:0]         pred_count;

  logic [BPM_W-1:0]    bpm_due_q[$];    // bpm words still owed by the block
  plan_row_t           plan_q[$];

  pace_t               pace;
  int                  hold_cycles;     // receiver hold-off, counted down below
  bit                  need_drain;
  int                  err_cnt;
  int                  words_sent;
  int                  bpm_seen;
  int                  reg_writes;
  int                  quiet;
  logic [BPM_W-1:0]    due_bpm;

  // Pulse-shaped stimulus state
  int                  beat_len;
  int                  beat_pos;
  int                  pulse_base;
  int                  pulse_amp;
  logic [TIME_W-1:0]   now_ms;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor: one sample in, at most one bpm out
  // -------------------------------------------------------------------------
  function automatic void predict_bpm(input logic [SMP_W-1:0] smp,
                                      input logic [TIME_W-1:0] now,
                                      output bit has_bpm,
                                      output logic [BPM_W-1:0] bpm);
    longint unsigned wt;
    longint unsigned lvl_next;
    longint unsigned mag;
    longint unsigned prod;
    longint          slope;
    bit              neg;
    logic [TIME_W-1:0] since_beat;
    logic [TIME_W-1:0] since_win;
    has_bpm = 1'b0;
    bpm     = '0;
    // weights above one clamp to one (level frozen)
    wt = (pred_cfg.filter_weight > WEIGHT_ONE) ? 64'd256 : 64'(pred_cfg.filter_weight);
    lvl_next = (wt * 64'(pred_level) + (64'd256 - wt) * (64'(smp) << FRAC_BITS_DEF)
                + 64'd128) >> 8;
    slope = longint'(lvl_next) - longint'(64'(pred_level));
    pred_level = lvl_next[19:0];

    // modular time differences, so wrap of time_ms is harmless
    since_beat = now - pred_last_beat;
    if (slope >= longint'(pred_peak) && since_beat > 32'(pred_cfg.min_beat_gap_ms)) begin
      pred_peak      = slope[20:0];
      pred_last_beat = now;
      if (pred_count != 16'hFFFF) pred_count = pred_count + 16'd1;
    end

    // sign-magnitude decay with rounding
    neg = (pred_peak < 0);
    mag = neg ? 64'(-longint'(pred_peak)) : 64'(longint'(pred_peak));
    mag = (mag * 64'(pred_cfg.decay_factor) + 64'd32768) >> 16;
    pred_peak = neg ? 21'(-longint'(mag)) : 21'(mag);

    since_win = now - pred_win_start;
    if (since_win >= 32'(pred_cfg.window_ms)) begin
      // no finger: window still restarts, nothing reported
      if (smp > pred_cfg.touch_threshold) begin
        prod    = 64'(pred_count) * 64'(pred_cfg.bpm_scale);
        bpm     = (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
        has_bpm = 1'b1;
      end
      pred_win_start = now;
      pred_count     = '0;
    end
  endfunction

  function automatic bit sender_idles();
    case (pace)
      PACE_RX_SLOW: return $urandom_range(0, 99) < 36;
      PACE_TX_SLOW: return $urandom_range(0, 99) < 62;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic plan_row_t word_row(input logic [SMP_W-1:0] smp,
                                         input logic [TIME_W-1:0] now,
                                         input exp_t how,
                                         input logic [BPM_W-1:0] pinned = '0);
    plan_row_t r;
    r.kind = ROW_WORD; r.idx = '0; r.val = '0;
    r.smp = smp; r.now = now; r.how = how; r.pinned = pinned;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    plan_row_t r;
    r.kind = ROW_REG; r.idx = idx; r.val = val;
    r.smp = '0; r.now = '0; r.how = EXP_NONE; r.pinned = '0;
    return r;
  endfunction

  // Heartbeat-like waveform: fast upstroke, slow decay, noise, some junk.
  function automatic logic [SMP_W-1:0] next_pulse_sample();
    int v;
    if (beat_pos == 0) begin
      beat_len   = $urandom_range(6, 25);
      pulse_base = $urandom_range(0, 2500);
      pulse_amp  = $urandom_range(100, 1595);
    end
    if (beat_pos < 2) v = pulse_base + pulse_amp * (beat_pos + 1) / 2;
    else              v = pulse_base + pulse_amp - pulse_amp * (beat_pos - 1) / (beat_len - 1);
    v = v + $urandom_range(0, 31);
    if (v > 4095) v = 4095;
    if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 4095);
    beat_pos = (beat_pos + 1) % beat_len;
    return v[SMP_W-1:0];
  endfunction

  // Mostly forward steps; a few random jumps and small steps back.
  function automatic void advance_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)      now_ms = $urandom;
    else if (r < 5) now_ms = now_ms - $urandom_range(1, 100);
    else            now_ms = now_ms + $urandom_range(1, 60);
  endfunction

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------
  task automatic send_word(input logic [SMP_W-1:0] smp, input logic [TIME_W-1:0] now,
                           input exp_t how, input logic [BPM_W-1:0] pinned);
    bit               has_bpm;
    logic [BPM_W-1:0] bpm;
    while (sender_idles()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_W - SMP_W - TIME_W){1'b0}}, now, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_bpm(smp, now, has_bpm, bpm);
    words_sent++;
    need_drain = 1'b1;
    case (how)
      EXP_MODEL: if (has_bpm) bpm_due_q.push_back(bpm);
      EXP_BPM:   bpm_due_q.push_back(pinned);
      default:   ;
    endcase
  endtask

  // Stop offering, wait for owed words, then let a no-result word clear.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (bpm_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    need_drain = 1'b0;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    if (need_drain) drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FILTER_WEIGHT:   pred_cfg.filter_weight   = val[WEIGHT_W-1:0];
      REG_DECAY_FACTOR:    pred_cfg.decay_factor    = val[DECAY_W-1:0];
      REG_MIN_BEAT_GAP_MS: pred_cfg.min_beat_gap_ms = val[GAP_W-1:0];
      REG_WINDOW_MS:       pred_cfg.window_ms       = val[WIN_W-1:0];
      REG_BPM_SCALE:       pred_cfg.bpm_scale       = val[SCALE_W-1:0];
      REG_TOUCH_THRESHOLD: pred_cfg.touch_threshold = val[THRESH_W-1:0];
      default:             ;
    endcase
    reg_writes++;
  endtask

  task automatic random_config();
    cfg_write(REG_FILTER_WEIGHT, ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(257, 511))
                                                             : CFG_W'($urandom_range(96, 256)));
    cfg_write(REG_DECAY_FACTOR,    CFG_W'($urandom_range(55000, 65535)));
    cfg_write(REG_MIN_BEAT_GAP_MS, CFG_W'($urandom_range(0, 400)));
    cfg_write(REG_WINDOW_MS,       CFG_W'($urandom_range(20, 800)));
    cfg_write(REG_BPM_SCALE,       CFG_W'($urandom_range(1, 255)));
    cfg_write(REG_TOUCH_THRESHOLD, CFG_W'($urandom_range(0, 2000)));
  endtask

  // -------------------------------------------------------------------------
  // Receiver side: random ready, or a long hold-off when asked
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      case (pace)
        PACE_RX_SLOW: m_tready <= ($urandom_range(0, 99) >= 62);
        PACE_TX_SLOW: m_tready <= ($urandom_range(0, 99) >= 36);
        default:      m_tready <= 1'b1;
      endcase
    end
  end

  // Result check against the oldest owed bpm
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      bpm_seen++;
      if (bpm_due_q.size() == 0) begin
        err_cnt++;
        $display("%0t: bpm word with none owed: expected -, actual %0d", $time, m_tdata);
      end else begin
        due_bpm = bpm_due_q.pop_front();
        if (m_tdata !== due_bpm) begin
          err_cnt++;
          $display("%0t: bpm mismatch: expected %0d, actual %0d", $time, due_bpm, m_tdata);
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main
    plan_row_t r;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    m_tready    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    rst         <= 1'b1;
    pace        = PACE_RX_SLOW;
    hold_cycles = 0;
    need_drain  = 1'b0;
    err_cnt     = 0;
    words_sent  = 0;
    bpm_seen    = 0;
    reg_writes  = 0;
    quiet       = 0;
    beat_len    = 1;
    beat_pos    = 0;
    pulse_base  = 0;
    pulse_amp   = 0;
    now_ms      = '0;

    pred_cfg.filter_weight   = FILTER_WEIGHT_RST;
    pred_cfg.decay_factor    = DECAY_FACTOR_RST;
    pred_cfg.min_beat_gap_ms = MIN_BEAT_GAP_MS_RST;
    pred_cfg.window_ms       = WINDOW_MS_RST;
    pred_cfg.bpm_scale       = BPM_SCALE_RST;
    pred_cfg.touch_threshold = TOUCH_THRESHOLD_RST;
    pred_level     = '0;
    pred_peak      = '0;
    pred_last_beat = '0;
    pred_win_start = '0;
    pred_count     = '0;

    // Directed plan. Defaults after reset: first window closes at 15000 ms,
    // first beat needs time above 300 ms.
    plan_q.push_back(word_row(12'd0,    32'd0,     EXP_NONE));
    plan_q.push_back(word_row(12'd4095, 32'd1000,  EXP_MODEL));
    plan_q.push_back(word_row(12'd4095, 32'd15000, EXP_MODEL));
    plan_q.push_back(word_row(12'd1000, 32'd16000, EXP_MODEL));
    // zero scale and zero window: every sample closes, bpm reads 0
    plan_q.push_back(reg_row(REG_BPM_SCALE, 16'd0));
    plan_q.push_back(reg_row(REG_WINDOW_MS, 16'd0));
    plan_q.push_back(word_row(12'd4095, 32'd16001, EXP_BPM, 16'd0));
    plan_q.push_back(word_row(12'd0,    32'd16002, EXP_NONE));   // no finger
    // raw pass-through, no decay, no gap, 1 ms window, max scale
    plan_q.push_back(reg_row(REG_BPM_SCALE,       16'd255));
    plan_q.push_back(reg_row(REG_WINDOW_MS,       16'd1));
    plan_q.push_back(reg_row(REG_FILTER_WEIGHT,   16'd0));
    plan_q.push_back(reg_row(REG_MIN_BEAT_GAP_MS, 16'd0));
    plan_q.push_back(reg_row(REG_DECAY_FACTOR,    16'd0));
    plan_q.push_back(reg_row(REG_TOUCH_THRESHOLD, 16'd0));
    plan_q.push_back(word_row(12'd4095, 32'hFFFF_FFF0, EXP_MODEL));
    plan_q.push_back(word_row(12'd4095, 32'hFFFF_FFF8, EXP_MODEL));
    plan_q.push_back(word_row(12'd4095, 32'h0000_0004, EXP_MODEL)); // time wraps
    plan_q.push_back(word_row(12'd1,    32'd5,         EXP_MODEL));
    plan_q.push_back(word_row(12'd2,    32'd5,         EXP_MODEL)); // same ms
    // weight above one freezes the level; max threshold means never touched
    plan_q.push_back(reg_row(REG_FILTER_WEIGHT,   16'd511));
    plan_q.push_back(reg_row(REG_TOUCH_THRESHOLD, 16'd4095));
    plan_q.push_back(word_row(12'd4095, 32'd10, EXP_NONE));
    plan_q.push_back(word_row(12'd2048, 32'd20, EXP_NONE));
    // other ends of the ranges
    plan_q.push_back(reg_row(REG_FILTER_WEIGHT,   16'd256));
    plan_q.push_back(reg_row(REG_DECAY_FACTOR,    16'd65535));
    plan_q.push_back(reg_row(REG_MIN_BEAT_GAP_MS, 16'd65535));
    plan_q.push_back(reg_row(REG_WINDOW_MS,       16'd65535));
    plan_q.push_back(reg_row(REG_TOUCH_THRESHOLD, 16'd1900));
    plan_q.push_back(word_row(12'd3000, 32'd100,         EXP_MODEL));
    plan_q.push_back(word_row(12'd3000, 32'd65635,       EXP_MODEL));
    plan_q.push_back(word_row(12'd0,    32'hFFFF_FFFF,   EXP_MODEL));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_q[i]) begin
      r = plan_q[i];
      if (r.kind == ROW_REG) cfg_write(r.idx, r.val);
      else                   send_word(r.smp, r.now, r.how, r.pinned);
    end

    // Random pulse streams: two phases per idle mix
    for (int ph = 0; ph < 6; ph++) begin
      pace = (ph < 2) ? PACE_RX_SLOW : (ph < 4) ? PACE_TX_SLOW : PACE_FULL;
      random_config();
      for (int k = 0; k < 110; k++) begin
        advance_time();
        send_word(next_pulse_sample(), now_ms, EXP_MODEL, '0);
      end
    end

    // Back-pressure: every sample reports, receiver holds off for a long
    // stretch, so the output and input registers fill and s_tready drops.
    pace = PACE_FULL;
    cfg_write(REG_WINDOW_MS,       16'd0);
    cfg_write(REG_TOUCH_THRESHOLD, 16'd0);
    cfg_write(REG_BPM_SCALE,       CFG_W'($urandom_range(1, 255)));
    hold_cycles = HOLD_LEN;
    for (int k = 0; k < 40; k++) begin
      advance_time();
      send_word(SMP_W'($urandom_range(1, 4095)), now_ms, EXP_MODEL, '0);
    end

    // bpm saturation: a beat on every flat sample, then one long window close
    cfg_write(REG_FILTER_WEIGHT,   16'd0);
    cfg_write(REG_DECAY_FACTOR,    16'd0);
    cfg_write(REG_MIN_BEAT_GAP_MS, 16'd0);
    cfg_write(REG_WINDOW_MS,       16'd65535);
    cfg_write(REG_BPM_SCALE,       16'd255);
    for (int k = 0; k < 300; k++) begin
      now_ms = now_ms + 32'd1;
      send_word(12'd4000, now_ms, EXP_MODEL, '0);
    end
    now_ms = now_ms + 32'd70000;
    send_word(12'd4000, now_ms, EXP_MODEL, '0);

    drain();
    if (bpm_due_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d bpm words never arrived", $time, bpm_due_q.size());
    end

    $display("Run: %0d sample words, %0d register writes, %0d bpm words checked",
             words_sent, reg_writes, bpm_seen);
    $display("Covered weight clamp, zero window and scale, time wrap, stall, bpm saturation");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pbrc_pkg.sv
rtl/core/pbrc_cfg_regs.sv
rtl/core/pbrc_beat_core.sv
rtl/core/pulse_beat_rate_counter_unit.sv
tb/tb_pulse_beat_rate_counter_unit.sv
